@@ hdl/mbq_pkg.sv @@
// shared widths, codes and types of the multichannel biquad lowpass unit
package mbq_pkg;

   localparam int CHAN_W    = 3;
   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 24;
   localparam int PROD_W    = SAMPLE_W + COEF_W;
   localparam int ACC_W     = PROD_W + 4;
   localparam int FRAC_W    = 20;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_W);
   localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(1 << (FRAC_W - 1));
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      COEF_B0 = 3'd0,
      COEF_B1 = 3'd1,
      COEF_B2 = 3'd2,
      COEF_A1 = 3'd3,
      COEF_A2 = 3'd4
   } coef_idx_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x1;
      logic signed [SAMPLE_W-1:0] x2;
      logic signed [SAMPLE_W-1:0] y1;
      logic signed [SAMPLE_W-1:0] y2;
   } hist_entry_type;

endpackage

@@ hdl/mbq_ifs.sv @@
// valid/ready channel interfaces for samples, results and coefficient writes
interface mbq_req_if import mbq_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CHAN_W-1:0]          chan;
   logic signed [SAMPLE_W-1:0] sample_in;

   modport source (output valid, chan, sample_in, input ready);
   modport sink (input valid, chan, sample_in, output ready);
endinterface

interface mbq_rsp_if import mbq_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CHAN_W-1:0]          chan_out;
   logic signed [SAMPLE_W-1:0] sample_out;

   modport source (output valid, chan_out, sample_out, input ready);
   modport sink (input valid, chan_out, sample_out, output ready);
endinterface

interface mbq_csr_if import mbq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COEF_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/multichannel_biquad_lowpass_unit.sv @@
// multichannel direct form I biquad with per-channel history memory
//
//  channel   role     payload
//  req_bus   sink     chan, sample_in
//  rsp_bus   source   chan_out, sample_out
//  csr_bus   sink     index, data (coefficients b0 b1 b2 a1 a2)
//
// from transfer in to result register: history read at the transfer, then products,
// sum and round, each registered in turn
// one sample per cycle across different channels unless the result stalls; a sample
// whose channel is still in the product or sum stage waits
// history reads are forwarded from the write-back in the same cycle
// reset clears coefficients to unity gain and marks all history entries empty (zero)
// a stalled result register holds the whole pipeline; coefficient writes always accepted
module multichannel_biquad_lowpass_unit
   import mbq_pkg::*;
#(
   parameter int MAX_CHANNELS = 8
) (
   input  logic      clock,
   input  logic      reset,
   mbq_req_if.sink   req_bus,
   mbq_rsp_if.source rsp_bus,
   mbq_csr_if.sink   csr_bus
);

   localparam int ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int WIDE_W = (ADDR_W > CHAN_W) ? ADDR_W : CHAN_W;

   // coefficients
   logic signed [COEF_W-1:0] coef_b0_ff, coef_b1_ff, coef_b2_ff, coef_a1_ff, coef_a2_ff;

   // history memory
   hist_entry_type          hist_mem [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0] hist_vld_ff;
   hist_entry_type          rd_data_ff;
   logic                    rd_vld_ff;
   logic                    fwd_ff;
   hist_entry_type          fwd_data_ff;

   // pipeline
   logic                       adv, hazard, req_fire;
   logic [WIDE_W-1:0]          req_wide;
   logic [ADDR_W-1:0]          req_addr;
   logic                       req_inr;

   logic                       s1_v_ff, s1_inr_ff;
   logic [CHAN_W-1:0]          s1_chan_ff;
   logic signed [SAMPLE_W-1:0] s1_x_ff;
   hist_entry_type             s1_hist;

   logic                       s2_v_ff, s2_inr_ff;
   logic [CHAN_W-1:0]          s2_chan_ff;
   logic signed [SAMPLE_W-1:0] s2_x_ff, s2_x1_ff, s2_y1_ff;
   logic signed [PROD_W-1:0]   s2_p0_ff, s2_p1_ff, s2_p2_ff, s2_p3_ff, s2_p4_ff;
   logic signed [PROD_W-1:0]   s2_p0_in, s2_p1_in, s2_p2_in, s2_p3_in, s2_p4_in;

   logic                       s3_v_ff, s3_inr_ff;
   logic [CHAN_W-1:0]          s3_chan_ff;
   logic signed [SAMPLE_W-1:0] s3_x_ff, s3_x1_ff, s3_y1_ff;
   logic signed [ACC_W-1:0]    s3_acc_ff, s3_acc_in;

   logic signed [ACC_W-1:0]    rnd_sum;
   logic signed [ACC_W-FRAC_W-1:0] rnd_y;
   logic signed [SAMPLE_W-1:0] sat_y;
   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [WIDE_W-1:0]          wr_wide;
   hist_entry_type             wr_data;

   logic                       rsp_v_ff;
   logic [CHAN_W-1:0]          rsp_chan_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;

   // handshakes
   assign adv      = !rsp_v_ff || rsp_bus.ready;
   assign req_wide = WIDE_W'(req_bus.chan);
   assign req_addr = req_wide[ADDR_W-1:0];
   assign req_inr  = 32'(req_bus.chan) < MAX_CHANNELS;
   assign hazard   = (s1_v_ff && s1_chan_ff == req_bus.chan) ||
                     (s2_v_ff && s2_chan_ff == req_bus.chan);
   assign req_bus.ready = adv && !hazard;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // coefficient writes
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff <= COEF_ONE;
         coef_b1_ff <= '0;
         coef_b2_ff <= '0;
         coef_a1_ff <= '0;
         coef_a2_ff <= '0;
      end else if (csr_bus.valid) begin
         case (coef_idx_type'(csr_bus.index))
            COEF_B0: coef_b0_ff <= csr_bus.data;
            COEF_B1: coef_b1_ff <= csr_bus.data;
            COEF_B2: coef_b2_ff <= csr_bus.data;
            COEF_A1: coef_a1_ff <= csr_bus.data;
            COEF_A2: coef_a2_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // write-back port
   assign wr_en   = adv && s3_v_ff && s3_inr_ff;
   assign wr_wide = WIDE_W'(s3_chan_ff);
   assign wr_addr = wr_wide[ADDR_W-1:0];
   assign wr_data = '{x1: s3_x_ff, x2: s3_x1_ff, y1: sat_y, y2: s3_y1_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
      if (req_fire) begin
         rd_data_ff  <= hist_mem[req_addr];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         if (wr_en) begin
            hist_vld_ff[wr_addr] <= 1'b1;
         end
         if (req_fire) begin
            rd_vld_ff <= hist_vld_ff[req_addr];
            fwd_ff    <= wr_en && wr_addr == req_addr;
         end
      end
   end

   // stage 1: history select and products
   always_comb begin
      if (fwd_ff) begin
         s1_hist = fwd_data_ff;
      end else if (rd_vld_ff) begin
         s1_hist = rd_data_ff;
      end else begin
         s1_hist = '0;
      end
      s2_p0_in = coef_b0_ff * s1_x_ff;
      s2_p1_in = coef_b1_ff * s1_hist.x1;
      s2_p2_in = coef_b2_ff * s1_hist.x2;
      s2_p3_in = coef_a1_ff * s1_hist.y1;
      s2_p4_in = coef_a2_ff * s1_hist.y2;
   end

   // stage 2: sum
   assign s3_acc_in = ACC_W'(s2_p0_ff) + ACC_W'(s2_p1_ff) + ACC_W'(s2_p2_ff)
                    - ACC_W'(s2_p3_ff) - ACC_W'(s2_p4_ff);

   // stage 3: round half up and saturate
   always_comb begin
      rnd_sum = s3_acc_ff + ROUND_HALF;
      rnd_y   = rnd_sum[ACC_W-1:FRAC_W];
      if (rnd_y > (ACC_W-FRAC_W)'(SAMPLE_MAX)) begin
         sat_y = SAMPLE_MAX;
      end else if (rnd_y < (ACC_W-FRAC_W)'(SAMPLE_MIN)) begin
         sat_y = SAMPLE_MIN;
      end else begin
         sat_y = rnd_y[SAMPLE_W-1:0];
      end
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff  <= req_fire;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         rsp_v_ff <= s3_v_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_chan_ff <= req_bus.chan;
         s1_inr_ff  <= req_inr;
         s1_x_ff    <= req_bus.sample_in;
      end
      if (adv) begin
         s2_chan_ff    <= s1_chan_ff;
         s2_inr_ff     <= s1_inr_ff;
         s2_x_ff       <= s1_x_ff;
         s2_x1_ff      <= s1_hist.x1;
         s2_y1_ff      <= s1_hist.y1;
         s2_p0_ff      <= s2_p0_in;
         s2_p1_ff      <= s2_p1_in;
         s2_p2_ff      <= s2_p2_in;
         s2_p3_ff      <= s2_p3_in;
         s2_p4_ff      <= s2_p4_in;
         s3_chan_ff    <= s2_chan_ff;
         s3_inr_ff     <= s2_inr_ff;
         s3_x_ff       <= s2_x_ff;
         s3_x1_ff      <= s2_x1_ff;
         s3_y1_ff      <= s2_y1_ff;
         s3_acc_ff     <= s3_acc_in;
         rsp_chan_ff   <= s3_chan_ff;
         rsp_sample_ff <= s3_inr_ff ? sat_y : '0;
      end
   end

   assign rsp_bus.valid      = rsp_v_ff;
   assign rsp_bus.chan_out   = rsp_chan_ff;
   assign rsp_bus.sample_out = rsp_sample_ff;

   // checks
   a_no_same_chan_in_flight: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && s2_v_ff |-> s1_chan_ff != s2_chan_ff)
      else $error("two items of one channel in product and sum stages");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> 32'(s3_chan_ff) < MAX_CHANNELS)
      else $error("history write to channel beyond memory");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && !rsp_bus.ready |=> $stable(s3_v_ff) && $stable(s3_acc_ff))
      else $error("pipeline moved while result stalled");

   a_no_accept_on_hazard: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !(s1_v_ff && s1_chan_ff == req_bus.chan))
      else $error("accepted sample whose channel is in the product stage");

endmodule
